FILE: hdl/damped_oscillator_control_shaper_assert.svh
// Assertion macros shared by the oscillator shaper modules.
// Expects signals named clk and rst_n in the scope of use.
`ifndef DAMPED_OSCILLATOR_CONTROL_SHAPER_ASSERT_SVH
`define DAMPED_OSCILLATOR_CONTROL_SHAPER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define DOCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define DOCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/docs_pkg.sv
// Shared types, codes and helper functions for the oscillator shaper.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package docs_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W  = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ST_W      = 48;   // Q16.32 state
    localparam int MUL_A_W   = 33;   // gain or clipped retain, signed
    localparam int MUL_B_W   = 25;   // half of a state word plus sign
    localparam int HALF_W    = 24;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int FULL_W    = 83;   // full product plus rounding headroom
    localparam int TERM_W    = 52;   // rounded product term
    localparam int ACC_W     = 54;   // state plus two terms

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_RET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_RET  = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0] GAIN_RST   = 32'd60870;
    localparam logic [CFG_W-1:0] RETAIN_RST = 32'd2146996749;
    localparam logic [CFG_W-1:0] RETAIN_ONE = 32'h8000_0000;

    // Coefficient select
    localparam logic [2:0] COEF_CG = 3'd0;
    localparam logic [2:0] COEF_SG = 3'd1;
    localparam logic [2:0] COEF_DG = 3'd2;
    localparam logic [2:0] COEF_SS = 3'd3;
    localparam logic [2:0] COEF_VR = 3'd4;
    localparam logic [2:0] COEF_PR = 3'd5;

    // Multiplicand source select
    localparam logic [1:0] SRC_SAMPLE = 2'd0;
    localparam logic [1:0] SRC_VEL    = 2'd1;
    localparam logic [1:0] SRC_POS    = 2'd2;

    // Accumulator load select
    localparam logic [1:0] ACC_HOLD   = 2'd0;
    localparam logic [1:0] ACC_LD_VEL = 2'd1;
    localparam logic [1:0] ACC_LD_POS = 2'd2;
    localparam logic [1:0] ACC_LD_SUM = 2'd3;

    // State write select
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_VEL  = 2'd1;
    localparam logic [1:0] WR_POS  = 2'd2;

    // Saturation limits, in accumulator width
    localparam logic signed [ACC_W-1:0] ACC_ST_MAX =
        {{(ACC_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_ST_MIN =
        {{(ACC_W-ST_W+1){1'b1}}, {(ST_W-1){1'b0}}};

    // Controller to datapath command word
    typedef struct packed {
        logic [2:0] coef;
        logic [1:0] src;
        logic       mul_lo;
        logic       mul_hi;
        logic       add_acc;
        logic       neg;
        logic [1:0] acc_ld;
        logic [1:0] st_wr;
        logic       sample_ld;
        logic       out_ld;
    } cmd_t;

    // Retain factor above one is held at one
    function automatic logic signed [MUL_A_W-1:0] retain_clip(input logic [CFG_W-1:0] raw);
        if (raw > RETAIN_ONE)
            return {1'b0, RETAIN_ONE};
        return {1'b0, raw};
    endfunction

    // Clamp a sum to the signed state range
    function automatic logic signed [ST_W-1:0] sat_state(input logic signed [ACC_W-1:0] x);
        if (x > ACC_ST_MAX)
            return ACC_ST_MAX[ST_W-1:0];
        if (x < ACC_ST_MIN)
            return ACC_ST_MIN[ST_W-1:0];
        return x[ST_W-1:0];
    endfunction

endpackage

FILE: hdl/docs_ctrl.sv
// Sequencer for the oscillator shaper: steps the shared multiplier and
// accumulator through one Euler update. Depends on docs_pkg and the assert header.
`timescale 1ns / 1ps
`include "damped_oscillator_control_shaper_assert.svh"

module docs_ctrl
    import docs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CG_LO = 5'd1;
    localparam logic [4:0] ST_CG_HI = 5'd2;
    localparam logic [4:0] ST_SG_LO = 5'd3;
    localparam logic [4:0] ST_SG_HI = 5'd4;
    localparam logic [4:0] ST_V_SUM = 5'd5;
    localparam logic [4:0] ST_VR_LO = 5'd6;
    localparam logic [4:0] ST_VR_HI = 5'd7;
    localparam logic [4:0] ST_V_RET = 5'd8;
    localparam logic [4:0] ST_DG_LO = 5'd9;
    localparam logic [4:0] ST_DG_HI = 5'd10;
    localparam logic [4:0] ST_SS_LO = 5'd11;
    localparam logic [4:0] ST_SS_HI = 5'd12;
    localparam logic [4:0] ST_P_SUM = 5'd13;
    localparam logic [4:0] ST_PR_LO = 5'd14;
    localparam logic [4:0] ST_PR_HI = 5'd15;
    localparam logic [4:0] ST_P_RET = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.sample_ld = in_valid;
                if (in_valid)
                    state_next = ST_CG_LO;
            end
            ST_CG_LO:
            begin
                cmd.coef   = COEF_CG;
                cmd.src    = SRC_SAMPLE;
                cmd.mul_lo = 1'b1;
                cmd.acc_ld = ACC_LD_VEL;
                state_next = ST_CG_HI;
            end
            ST_CG_HI:
            begin
                cmd.coef   = COEF_CG;
                cmd.src    = SRC_SAMPLE;
                cmd.mul_hi = 1'b1;
                state_next = ST_SG_LO;
            end
            ST_SG_LO:
            begin
                cmd.coef    = COEF_SG;
                cmd.src     = SRC_POS;
                cmd.mul_lo  = 1'b1;
                cmd.add_acc = 1'b1;
                cmd.acc_ld  = ACC_LD_SUM;
                state_next  = ST_SG_HI;
            end
            ST_SG_HI:
            begin
                cmd.coef   = COEF_SG;
                cmd.src    = SRC_POS;
                cmd.mul_hi = 1'b1;
                state_next = ST_V_SUM;
            end
            ST_V_SUM:
            begin
                cmd.add_acc = 1'b1;
                cmd.neg     = 1'b1;
                cmd.st_wr   = WR_VEL;
                state_next  = ST_VR_LO;
            end
            ST_VR_LO:
            begin
                cmd.coef   = COEF_VR;
                cmd.src    = SRC_VEL;
                cmd.mul_lo = 1'b1;
                state_next = ST_VR_HI;
            end
            ST_VR_HI:
            begin
                cmd.coef   = COEF_VR;
                cmd.src    = SRC_VEL;
                cmd.mul_hi = 1'b1;
                state_next = ST_V_RET;
            end
            ST_V_RET:
            begin
                cmd.st_wr  = WR_VEL;
                cmd.acc_ld = ACC_LD_POS;
                state_next = ST_DG_LO;
            end
            ST_DG_LO:
            begin
                cmd.coef   = COEF_DG;
                cmd.src    = SRC_SAMPLE;
                cmd.mul_lo = 1'b1;
                state_next = ST_DG_HI;
            end
            ST_DG_HI:
            begin
                cmd.coef   = COEF_DG;
                cmd.src    = SRC_SAMPLE;
                cmd.mul_hi = 1'b1;
                state_next = ST_SS_LO;
            end
            ST_SS_LO:
            begin
                cmd.coef    = COEF_SS;
                cmd.src     = SRC_VEL;
                cmd.mul_lo  = 1'b1;
                cmd.add_acc = 1'b1;
                cmd.acc_ld  = ACC_LD_SUM;
                state_next  = ST_SS_HI;
            end
            ST_SS_HI:
            begin
                cmd.coef   = COEF_SS;
                cmd.src    = SRC_VEL;
                cmd.mul_hi = 1'b1;
                state_next = ST_P_SUM;
            end
            ST_P_SUM:
            begin
                cmd.add_acc = 1'b1;
                cmd.st_wr   = WR_POS;
                state_next  = ST_PR_LO;
            end
            ST_PR_LO:
            begin
                cmd.coef   = COEF_PR;
                cmd.src    = SRC_POS;
                cmd.mul_lo = 1'b1;
                state_next = ST_PR_HI;
            end
            ST_PR_HI:
            begin
                cmd.coef   = COEF_PR;
                cmd.src    = SRC_POS;
                cmd.mul_hi = 1'b1;
                state_next = ST_P_RET;
            end
            ST_P_RET:
            begin
                cmd.st_wr  = WR_POS;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_ld)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    `DOCS_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_reg == ST_CG_LO, "accepted word did not start a step")
    `DOCS_ASSERT_IMP(a_no_overwrite, cmd.out_ld, !out_valid_reg || out_ready, "result overwritten before taken")
    `DOCS_ASSERT_IMP(a_hi_after_lo, cmd.mul_hi, $past(cmd.mul_lo) && ($past(cmd.coef) == cmd.coef), "high pass without matching low pass")

endmodule

FILE: hdl/docs_dpath.sv
// Datapath of the oscillator shaper: config registers, shared 33x25
// multiplier, accumulator, state and output register. Depends on docs_pkg.
`timescale 1ns / 1ps

module docs_dpath
    import docs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    input  cmd_t                        cmd,
    output logic signed [SAMPLE_W-1:0]  position_out
);

    logic [CFG_W-1:0]          coupling_gain_reg;
    logic [CFG_W-1:0]          spring_gain_reg;
    logic [CFG_W-1:0]          drag_gain_reg;
    logic [CFG_W-1:0]          step_scale_reg;
    logic [CFG_W-1:0]          velocity_retain_reg;
    logic [CFG_W-1:0]          position_retain_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [ST_W-1:0]     vel_reg;
    logic signed [ST_W-1:0]     pos_reg;
    logic signed [ST_W-1:0]     vel_next;
    logic signed [ST_W-1:0]     pos_next;
    logic signed [PROD_W-1:0]   lo_reg;
    logic signed [TERM_W-1:0]   term_reg;
    logic signed [TERM_W-1:0]   term_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [SAMPLE_W-1:0] position_out_reg;
    logic signed [SAMPLE_W-1:0] position_out_next;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [ST_W-1:0]     mul_src;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [FULL_W-1:0]   full;
    logic signed [FULL_W-1:0]   rnd;
    logic                       use_q31;
    logic signed [ACC_W-1:0]    term_ext;
    logic signed [ACC_W-1:0]    sum;
    logic signed [ST_W-1:0]     sum_sat;
    logic signed [ST_W:0]       pos_rnd;
    logic signed [ST_W-16:0]    pos_q16;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_gain_reg   <= GAIN_RST;
            spring_gain_reg     <= GAIN_RST;
            drag_gain_reg       <= GAIN_RST;
            step_scale_reg      <= GAIN_RST;
            velocity_retain_reg <= RETAIN_RST;
            position_retain_reg <= RETAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_COUPLING: coupling_gain_reg   <= cfg_data;
                REG_SPRING:   spring_gain_reg     <= cfg_data;
                REG_DRAG:     drag_gain_reg       <= cfg_data;
                REG_STEP:     step_scale_reg      <= cfg_data;
                REG_VEL_RET:  velocity_retain_reg <= cfg_data;
                REG_POS_RET:  position_retain_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Coefficient operand
    always_comb
    begin
        case (cmd.coef)
            COEF_CG: mul_a = {coupling_gain_reg[CFG_W-1], coupling_gain_reg};
            COEF_SG: mul_a = {spring_gain_reg[CFG_W-1], spring_gain_reg};
            COEF_DG: mul_a = {drag_gain_reg[CFG_W-1], drag_gain_reg};
            COEF_SS: mul_a = {step_scale_reg[CFG_W-1], step_scale_reg};
            COEF_VR: mul_a = retain_clip(velocity_retain_reg);
            COEF_PR: mul_a = retain_clip(position_retain_reg);
            default: mul_a = '0;
        endcase
        use_q31 = cmd.coef inside {COEF_VR, COEF_PR};
    end

    // Q16.32 operand; sample widens exactly
    always_comb
    begin
        case (cmd.src)
            SRC_SAMPLE: mul_src = {sample_reg, 16'h0000};
            SRC_VEL:    mul_src = vel_reg;
            SRC_POS:    mul_src = pos_reg;
            default:    mul_src = '0;
        endcase
    end

    // Low pass takes the unsigned low half, high pass the signed high half
    assign mul_b = cmd.mul_hi ? {mul_src[ST_W-1], mul_src[ST_W-1:HALF_W]}
                              : {1'b0, mul_src[HALF_W-1:0]};
    assign mul_p = mul_a * mul_b;

    // Recombine halves, round half up, shift to Q16.32
    assign rnd  = use_q31 ? (FULL_W'(1) <<< 30) : (FULL_W'(1) <<< 27);
    assign full = ({{(FULL_W-PROD_W){mul_p[PROD_W-1]}}, mul_p} <<< HALF_W)
                + {{(FULL_W-PROD_W){lo_reg[PROD_W-1]}}, lo_reg} + rnd;
    assign term_next = use_q31 ? full[31+TERM_W-1:31] : full[28+TERM_W-1:28];

    // Accumulate and saturate
    assign term_ext = {{(ACC_W-TERM_W){term_reg[TERM_W-1]}}, term_reg};
    assign sum      = (cmd.add_acc ? acc_reg : '0) + (cmd.neg ? -term_ext : term_ext);
    assign sum_sat  = sat_state(sum);

    always_comb
    begin
        case (cmd.acc_ld)
            ACC_LD_VEL: acc_next = {{(ACC_W-ST_W){vel_reg[ST_W-1]}}, vel_reg};
            ACC_LD_POS: acc_next = {{(ACC_W-ST_W){pos_reg[ST_W-1]}}, pos_reg};
            ACC_LD_SUM: acc_next = sum;
            default:    acc_next = acc_reg;
        endcase
        vel_next = (cmd.st_wr == WR_VEL) ? sum_sat : vel_reg;
        pos_next = (cmd.st_wr == WR_POS) ? sum_sat : pos_reg;
    end

    // Output: round position to Q16.16 and clamp
    assign pos_rnd = {pos_reg[ST_W-1], pos_reg} + (ST_W+1)'(32768);
    assign pos_q16 = pos_rnd[ST_W:16];

    always_comb
    begin
        if (pos_q16 > $signed({2'b00, {(SAMPLE_W-1){1'b1}}}))
            position_out_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (pos_q16 < $signed({2'b11, {(SAMPLE_W-1){1'b0}}}))
            position_out_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            position_out_next = pos_q16[SAMPLE_W-1:0];
    end

    // Oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            vel_reg <= vel_next;
            pos_reg <= pos_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.sample_ld)
            sample_reg <= sample_in;
        if (cmd.mul_lo)
            lo_reg <= mul_p;
        if (cmd.mul_hi)
            term_reg <= term_next;
        acc_reg <= acc_next;
        if (cmd.out_ld)
            position_out_reg <= position_out_next;
    end

    assign position_out = position_out_reg;

endmodule

FILE: hdl/damped_oscillator_control_shaper.sv
// Damped oscillator control shaper: one word in, one position word out.
// A new word is accepted only once the previous word's update is through; the sequencer drives the
// single 33x25 multiplier through two passes for each of six products, four sum/write-back
// steps, the accept and the output load; a result still waiting holds the sequencer.
// The next word is accepted while a finished result waits in the output register.
// Reset (async, active low) zeroes velocity and position and restores register defaults.
`timescale 1ns / 1ps

module damped_oscillator_control_shaper
    import docs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  position_out
);

    cmd_t cmd;

    // Sequencer
    docs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    docs_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_in    (sample_in),
        .cmd          (cmd),
        .position_out (position_out)
    );

endmodule
